/* rtl/core/dnle_pkg.sv */
// Shared types and constants for the DNS name label encoder.
package dnle_pkg;

  localparam int unsigned MAX_LABEL_DEF = 62;
  // Label length counter width, fixed by the 6-bit length byte range.
  localparam int unsigned CNT_W         = 6;
  // Label RAM address: bank bit on top of the byte index.
  localparam int unsigned ADDR_W        = CNT_W + 1;
  localparam int unsigned CMD_DEPTH     = 2;
  localparam int unsigned CMD_PTR_W     = $clog2(CMD_DEPTH);
  localparam int unsigned OUT_DEPTH     = 2;
  localparam int unsigned OUT_PTR_W     = $clog2(OUT_DEPTH);

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // Flush request from front to back: one per dot or end of name.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             is_end;
    logic             ovf;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // Back end hands a label bank back to the front.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       ovf;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_DATA,
    BK_TERM
  } back_state_t;

endpackage

/* rtl/core/dnle_label_ram.sv */
// Label byte RAM: two banks, one write port, one registered read port.
module dnle_label_ram (
  input  logic                         clk,
  input  dnle_pkg::ram_wr_t            wr,
  input  logic                         rd_en,
  input  logic [dnle_pkg::ADDR_W-1:0]  rd_addr,
  output logic [7:0]                   rd_data
);
  import dnle_pkg::*;

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/dnle_front.sv */
// Front end: accepts characters, fills the current label bank, issues flush requests.
module dnle_front #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              is_end,
  output dnle_pkg::cmd_t    cmd,
  output logic              cmd_push,
  input  logic              cmd_full,
  output dnle_pkg::ram_wr_t wr,
  input  dnle_pkg::rel_t    rel,
  output logic [1:0]        busy
);
  import dnle_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LABEL);

  logic             wbank;
  logic [CNT_W-1:0] count;
  logic             ovf_seen;
  logic [1:0]       busy_next;
  logic             accept;
  logic             is_sep;

  assign in_ready = !busy[wbank] && !cmd_full;
  assign accept   = in_valid && in_ready;
  assign is_sep   = is_end || (in_char == DOT_CHAR);

  assign wr.en   = accept && !is_sep && (count < LIMIT);
  assign wr.addr = {wbank, count};
  assign wr.data = in_char;

  assign cmd_push   = accept && is_sep;
  assign cmd.bank   = wbank;
  assign cmd.len    = count;
  assign cmd.is_end = is_end;
  assign cmd.ovf    = ovf_seen;

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (cmd_push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wbank    <= 1'b0;
      count    <= '0;
      ovf_seen <= 1'b0;
      busy     <= '0;
    end else begin
      busy <= busy_next;
      if (cmd_push) begin
        wbank <= ~wbank;
        count <= '0;
        if (is_end) begin
          ovf_seen <= 1'b0;
        end
      end else if (accept) begin
        if (count < LIMIT) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf_seen <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/dnle_cmd_fifo.sv */
// Small request queue between the front and back ends.
module dnle_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dnle_pkg::cmd_t din,
  input  logic           pop,
  output dnle_pkg::cmd_t dout,
  output logic           empty,
  output logic           full
);
  import dnle_pkg::*;

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr;
  logic [CMD_PTR_W-1:0] rptr;
  logic [CMD_PTR_W:0]   cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign dout  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + CMD_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + CMD_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + (CMD_PTR_W+1)'(1);
        2'b01:   cnt <= cnt - (CMD_PTR_W+1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* rtl/core/dnle_back.sv */
// Back end: walks one flush request, reads label bytes and queues the results.
module dnle_back (
  input  logic                        clk,
  input  logic                        rst,
  input  dnle_pkg::cmd_t              cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        rd_en,
  output logic [dnle_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output dnle_pkg::rel_t              rel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dnle_pkg::result_t           out_res
);
  import dnle_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  cmd_t                 cur;
  logic [CNT_W-1:0]     idx;
  logic                 last_idx;
  logic                 can_issue;
  logic                 issue;
  logic                 iss_from_ram;
  result_t              iss_res;
  logic                 p_valid;
  logic                 p_from_ram;
  result_t              p_res;
  result_t              q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] q_wptr;
  logic [OUT_PTR_W-1:0] q_rptr;
  logic [OUT_PTR_W:0]   q_cnt;
  logic                 out_pop;
  logic [2:0]           occ;

  assign out_valid = (q_cnt != '0);
  assign out_res   = q[q_rptr];
  assign out_pop   = out_valid && out_ready;

  // Count the result in flight through the RAM read so the queue never overruns.
  assign occ       = 3'(q_cnt) + 3'(p_valid);
  assign can_issue = occ < (3'(OUT_DEPTH) + 3'(out_pop));
  assign last_idx  = (idx == cur.len - CNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          state_next = BK_LEN;
        end
      end
      BK_LEN: begin
        if (can_issue) begin
          if (cur.len != '0) begin
            state_next = BK_DATA;
          end else if (cur.is_end) begin
            state_next = BK_TERM;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_DATA: begin
        if (can_issue && last_idx) begin
          state_next = cur.is_end ? BK_TERM : BK_IDLE;
        end
      end
      BK_TERM: begin
        if (can_issue) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    issue        = 1'b0;
    iss_from_ram = 1'b0;
    iss_res      = '{data: NUL_BYTE, last: 1'b0, done: 1'b0, ovf: cur.ovf};
    rd_en        = 1'b0;
    rd_addr      = {cur.bank, idx};
    rel          = '{valid: 1'b0, bank: cur.bank};
    case (state)
      BK_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      BK_LEN: begin
        issue        = can_issue;
        iss_res.data = 8'(cur.len);
        iss_res.last = (cur.len == '0) && !cur.is_end;
        rel.valid    = can_issue && (cur.len == '0);
      end
      BK_DATA: begin
        issue        = can_issue;
        iss_from_ram = 1'b1;
        rd_en        = can_issue;
        iss_res.last = last_idx && !cur.is_end;
        rel.valid    = can_issue && last_idx;
      end
      BK_TERM: begin
        issue        = can_issue;
        iss_res.last = 1'b1;
        iss_res.done = 1'b1;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      p_valid <= 1'b0;
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_cnt   <= '0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
      if (p_valid) begin
        q_wptr <= q_wptr + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        q_rptr <= q_rptr + OUT_PTR_W'(1);
      end
      case ({p_valid, out_pop})
        2'b10:   q_cnt <= q_cnt + (OUT_PTR_W+1)'(1);
        2'b01:   q_cnt <= q_cnt - (OUT_PTR_W+1)'(1);
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == BK_LEN) begin
      idx <= '0;
    end else if (issue && state == BK_DATA) begin
      idx <= idx + CNT_W'(1);
    end
    p_from_ram <= iss_from_ram;
    p_res      <= iss_res;
    if (p_valid) begin
      q[q_wptr] <= '{data: (p_from_ram ? rd_data : p_res.data), last: p_res.last,
                     done: p_res.done, ovf: p_res.ovf};
    end
  end

endmodule

/* rtl/core/dns_name_label_encoder.sv */
// DNS name label encoder top level: dotted host name in, DNS wire-form bytes out.
// Flow: a dot or end-of-name request goes through the request queue, the back-end sequencer,
//   the RAM read stage and the output queue to its length byte, then one byte per cycle while
//   m_axis_tready stays high; characters give no result and are taken one per cycle while
//   the write bank is free and the queue has room. Each request is popped from the idle state.
// Reset: rst is synchronous, active high; clears counters, flags and queues, not the label RAM.
module dns_name_label_encoder #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // is_end: end of name, tdata ignored
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last: final byte caused by one request
  output logic [1:0] m_axis_tuser    // [0] name_done, [1] label_overflow
);
  import dnle_pkg::*;

  // Front/back handoff: flush requests go through a short queue, label bytes
  // live in two RAM banks so the front can fill one label while the back
  // drains the previous one.
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_empty;
  logic              cmd_full;
  ram_wr_t           wr;
  rel_t              rel;
  logic [1:0]        busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  result_t           res;

  dnle_front #(
    .MAX_LABEL(MAX_LABEL)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_char  (s_axis_tdata),
    .is_end   (s_axis_tlast),
    .cmd      (cmd_in),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .wr       (wr),
    .rel      (rel),
    .busy     (busy)
  );

  dnle_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .full  (cmd_full)
  );

  dnle_label_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dnle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rel       (rel),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.ovf, res.done};

  // Never push a request into a full queue.
  a_cmd_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("request queue overrun");

  // Only a bank the front handed over can come back.
  a_rel_busy_bank: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that is not busy");

  // The terminating zero always closes its request.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == NUL_BYTE))
    else $error("terminator byte not marked last or not zero");

endmodule

/* dv/tb_dns_name_label_encoder.sv */
// Self-checking testbench for the DNS name label encoder with its own wire-form predictor.
module tb_dns_name_label_encoder;
  import dnle_pkg::*;

  localparam int unsigned LABEL_CAP   = MAX_LABEL_DEF;
  localparam int          RANDOM_REQS = 250;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 24;

  int  cycles = 0;

  // Predict the wire-form bytes for each accepted request and check the bytes that leave.
  class wire_form_checker;
    logic [7:0]   label_bytes [LABEL_CAP];
    int unsigned  held_count;
    bit           overflow_flag;
    result_t      pending_bytes [$];
    int           mismatches;

    function new();
      held_count    = 0;
      overflow_flag = 0;
      mismatches    = 0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      mismatches++;
    endtask

    function void push_byte(input logic [7:0] b, input logic last, input logic done);
      result_t r;
      r.data = b;
      r.last = last;
      r.done = done;
      r.ovf  = overflow_flag;
      pending_bytes.push_back(r);
    endfunction

    // Emit length byte and held label; close the run here unless a terminator follows.
    function void flush_label(input bit closes_run);
      int unsigned n;
      n = held_count;
      push_byte(n[7:0], closes_run && (n == 0), 1'b0);
      for (int unsigned i = 0; i < n; i++)
        push_byte(label_bytes[i], closes_run && (i == n - 1), 1'b0);
      held_count = 0;
    endfunction

    function void note_request(input logic [7:0] ch, input logic is_end);
      if (is_end) begin
        flush_label(1'b0);
        push_byte(NUL_BYTE, 1'b1, 1'b1);
        overflow_flag = 0;
      end else if (ch == DOT_CHAR) begin
        flush_label(1'b1);
      end else if (held_count < LABEL_CAP) begin
        label_bytes[held_count] = ch;
        held_count++;
      end else begin
        overflow_flag = 1;
      end
    endfunction

    task check_byte(input logic [7:0] data, input logic last, input logic [1:0] user);
      result_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", data));
      end else begin
        want = pending_bytes.pop_front();
        if (data !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
        if (last !== want.last)
          report_mismatch($sformatf("run_last %b, want %b", last, want.last));
        if (user[0] !== want.done)
          report_mismatch($sformatf("name_done %b, want %b", user[0], want.done));
        if (user[1] !== want.ovf)
          report_mismatch($sformatf("label_overflow %b, want %b", user[1], want.ovf));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  int  reqs_accepted = 0;
  bit  calm = 0;       // no idling on either side while set
  bit  hold_off = 0;   // receiver stalls while set
  wire_form_checker board;

  dns_name_label_encoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dns_name_label_encoder test failed");
      $finish;
    end
  end

  // Receiver: check each accepted byte, then pick tready for the next cycle.
  // Hold tready low during the hold-off; idle at random otherwise unless calm.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (rst || hold_off)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  // Hold-off: once traffic is flowing, stall the receiver for a long stretch so the
  // block fills up and pushes back on its input.
  initial begin
    @(negedge rst);
    while (reqs_accepted < 60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one request and hold it until accepted; idle at random first unless calm.
  task send_req(input logic [7:0] ch, input logic is_end);
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= is_end;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(ch, is_end);
    reqs_accepted++;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == DOT_CHAR);
    return c;
  endfunction

  // Well-formed name: a few labels, mostly short, now and then past the buffer.
  task send_name();
    int unsigned nlab;
    int unsigned len;
    nlab = $urandom_range(4);
    for (int unsigned l = 0; l < nlab; l++) begin
      len = ($urandom_range(29) == 0) ? $urandom_range(66, 60) : $urandom_range(9);
      for (int unsigned i = 0; i < len; i++)
        send_req(label_char(), 1'b0);
      if (l + 1 < nlab || $urandom_range(9) == 0)
        send_req(DOT_CHAR, 1'b0);
    end
    send_req(8'($urandom_range(255)), 1'b1);
  endtask

  // Noise: arbitrary characters, dots and end marks in any order.
  task send_noise();
    int unsigned n;
    int unsigned pick;
    n = $urandom_range(12, 1);
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15)
        send_req(8'($urandom_range(255)), 1'b1);
      else if (pick < 35)
        send_req(DOT_CHAR, 1'b0);
      else
        send_req(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    int base;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty name, empty labels, zero and extreme characters, trailing dot.
    send_req(8'hFF, 1'b1);               // empty name
    send_req(DOT_CHAR, 1'b0);            // leading dot
    send_req(DOT_CHAR, 1'b0);            // consecutive dots
    send_req(8'h00, 1'b1);
    send_req(8'h00, 1'b0);               // zero character is a label byte
    send_req(8'hFF, 1'b0);
    send_req(8'h2D, 1'b0);
    send_req(8'h2F, 1'b0);
    send_req(DOT_CHAR, 1'b0);
    send_req(8'h7F, 1'b0);
    send_req(8'h80, 1'b1);
    send_req(8'h61, 1'b0);
    send_req(DOT_CHAR, 1'b0);            // trailing dot before the end mark
    send_req(DOT_CHAR, 1'b1);
    send_req(DOT_CHAR, 1'b0);
    send_req(8'h62, 1'b0);
    send_req(8'h00, 1'b1);

    // Random: mostly well-formed names, some noise; a calm window in the middle.
    base = reqs_accepted;
    while (reqs_accepted - base < RANDOM_REQS) begin
      calm <= (reqs_accepted - base > 120) && (reqs_accepted - base < 180);
      if ($urandom_range(99) < 80)
        send_name();
      else
        send_noise();
    end
    calm <= 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain: wait out every expected byte, then wait out TAIL_CYCLES as well.
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
      $display("dns_name_label_encoder test passed");
    end else begin
      $display("dns_name_label_encoder test failed");
    end
    $finish;
  end

endmodule
